FILE: hdl/ccq_pkg.sv
// Shared types and constants for the camera control input qualifier.
// No dependencies; imported by the core, the output buffer and the top level.
package ccq_pkg;

  localparam int unsigned CfgIndexWidth = 3;
  localparam int unsigned CfgDataWidth  = 10;

  // Configuration register indexes.
  localparam logic [CfgIndexWidth-1:0] REG_BUTTON_LOCKOUT = 3'd0;
  localparam logic [CfgIndexWidth-1:0] REG_MODE_LOCKOUT   = 3'd1;
  localparam logic [CfgIndexWidth-1:0] REG_RECORD_LOCKOUT = 3'd2;
  localparam logic [CfgIndexWidth-1:0] REG_DIAL_STABLE    = 3'd3;
  localparam logic [CfgIndexWidth-1:0] REG_HOLD_EXIT      = 3'd4;
  localparam logic [CfgIndexWidth-1:0] REG_RECORD_LINE_EN = 3'd5;
  localparam logic [CfgIndexWidth-1:0] REG_JOYSTICK_MASK  = 3'd6;

  // Reset values of the configuration registers.
  localparam logic [7:0] BUTTON_LOCKOUT_RST = 8'd20;
  localparam logic [7:0] MODE_LOCKOUT_RST   = 8'd10;
  localparam logic [7:0] RECORD_LOCKOUT_RST = 8'd30;
  localparam logic [3:0] DIAL_STABLE_RST    = 4'd5;
  localparam logic [9:0] HOLD_EXIT_RST      = 10'd300;
  localparam logic       RECORD_LINE_EN_RST = 1'b1;
  localparam logic [4:0] JOYSTICK_MASK_RST  = 5'h1F;

  localparam logic [9:0] HOLD_COUNT_MAX = 10'h3FF;

  // button_events bit positions
  localparam int unsigned EV_ALBUM      = 0;
  localparam int unsigned EV_FN_PRESS   = 1;
  localparam int unsigned EV_FN_RELEASE = 2;
  localparam int unsigned EV_DEL        = 3;
  localparam int unsigned EV_SHUTTER    = 4;
  localparam int unsigned EV_RECORD     = 5;
  localparam int unsigned EV_MENU       = 6;
  localparam int unsigned EV_EXIT       = 7;
  localparam int unsigned EV_JOY_BASE   = 8;
  localparam int unsigned NumJoy        = 5;
  localparam int unsigned NumEvents     = 13;

  typedef struct packed {
    logic [7:0] button_lockout_ticks;
    logic [7:0] mode_lockout_ticks;
    logic [7:0] record_lockout_ticks;
    logic [3:0] dial_stable_ticks;
    logic [9:0] hold_exit_ticks;
    logic       record_line_enable;
    logic [4:0] joystick_enable_mask;
  } cfg_t;

  typedef struct packed {
    logic [7:0] port0_levels;
    logic [7:0] port1_levels;
    logic       record_line_level;
    logic [4:0] joystick_levels;
  } sample_t;

  typedef struct packed {
    logic [NumEvents-1:0] button_events;
    logic                 dial_changed;
    logic [3:0]           dial_value;
    logic                 mode_changed;
    logic                 video_mode;
    logic                 scroll_valid;
    logic                 scroll_forward;
    logic                 scroll_switch_pressed;
    logic                 tick_skipped;
  } result_t;

endpackage

FILE: hdl/ccq_if.sv
// Valid/ready channel interfaces for the qualifier: pin samples in, results out.
// No dependencies.
interface ccq_sample_if;
  logic       valid;
  logic       ready;
  logic [7:0] port0_levels;
  logic [7:0] port1_levels;
  logic       record_line_level;
  logic [4:0] joystick_levels;

  modport source (output valid, port0_levels, port1_levels, record_line_level,
                  joystick_levels, input ready);
  modport sink   (input valid, port0_levels, port1_levels, record_line_level,
                  joystick_levels, output ready);
endinterface

interface ccq_result_if;
  logic        valid;
  logic        ready;
  logic [12:0] button_events;
  logic        dial_changed;
  logic [3:0]  dial_value;
  logic        mode_changed;
  logic        video_mode;
  logic        scroll_valid;
  logic        scroll_forward;
  logic        scroll_switch_pressed;
  logic        tick_skipped;

  modport source (output valid, button_events, dial_changed, dial_value, mode_changed,
                  video_mode, scroll_valid, scroll_forward, scroll_switch_pressed,
                  tick_skipped, input ready);
  modport sink   (input valid, button_events, dial_changed, dial_value, mode_changed,
                  video_mode, scroll_valid, scroll_forward, scroll_switch_pressed,
                  tick_skipped, output ready);
endinterface

FILE: hdl/ccq_core.sv
// Per-tick qualification logic and its history registers.
// Depends on ccq_pkg. Result is combinational from the sample and current state.
module ccq_core (
  input  logic             clk,
  input  logic             rst,
  input  ccq_pkg::cfg_t    cfg,
  input  logic             take,
  input  ccq_pkg::sample_t smp,
  output ccq_pkg::result_t res
);
  import ccq_pkg::*;

  logic [11:0] lockout_count, lockout_count_next;
  logic        cand_valid, cand_valid_next;
  logic [3:0]  dial_candidate, dial_candidate_next;
  logic [3:0]  dial_stable_count, dial_stable_count_next;
  logic        acc_valid, acc_valid_next;
  logic [3:0]  dial_accepted, dial_accepted_next;
  logic        last_video, last_video_next;
  logic [4:0]  last_port_buttons, last_port_buttons_next; // album, fn, del, shutter, menu
  logic        last_record_pressed, last_record_pressed_next;
  logic [4:0]  last_joystick_pressed, last_joystick_pressed_next;
  logic        last_encoder_a, last_encoder_a_next;
  logic [9:0]  hold_count, hold_count_next;
  logic        exit_sent, exit_sent_next;

  logic                 skip;
  logic [3:0]           d;
  logic [3:0]           cnt_inc;
  logic                 mchg, dchg;
  logic                 enc_a, enc_b, enc_sw, sv;
  logic                 rec, both_held;
  logic [NumEvents-1:0] ev;
  logic [3:0]           btn_cnt;
  logic [11:0]          lock;

  assign skip = (lockout_count != 12'd0);

  always_comb begin
    d       = ~smp.port0_levels[3:0];
    cnt_inc = dial_stable_count + 4'd1;
    ev      = '0;
    dchg    = 1'b0;

    dial_candidate_next    = dial_candidate;
    cand_valid_next        = cand_valid;
    dial_stable_count_next = dial_stable_count;
    dial_accepted_next     = dial_accepted;
    acc_valid_next         = acc_valid;

    if (cand_valid && d == dial_candidate) begin
      if (dial_stable_count < cfg.dial_stable_ticks) begin
        dial_stable_count_next = cnt_inc;
        if (cnt_inc == cfg.dial_stable_ticks && (!acc_valid || d != dial_accepted)) begin
          dchg               = 1'b1;
          dial_accepted_next = d;
          acc_valid_next     = 1'b1;
        end
      end
    end else begin
      dial_candidate_next    = d;
      cand_valid_next        = 1'b1;
      dial_stable_count_next = 4'd0;
    end

    mchg            = smp.port0_levels[7] != last_video;
    last_video_next = smp.port0_levels[7];

    ev[EV_ALBUM]      = last_port_buttons[0] & ~smp.port0_levels[5];
    ev[EV_FN_PRESS]   = last_port_buttons[1] & ~smp.port0_levels[6];
    ev[EV_FN_RELEASE] = ~last_port_buttons[1] & smp.port0_levels[6];
    ev[EV_DEL]        = last_port_buttons[2] & ~smp.port0_levels[4];

    enc_a  = smp.port1_levels[3];
    enc_b  = smp.port1_levels[2];
    enc_sw = smp.port1_levels[1];
    sv     = enc_a != last_encoder_a;
    last_encoder_a_next = enc_a;

    rec = ~smp.port1_levels[7] | (cfg.record_line_enable & ~smp.record_line_level);
    ev[EV_SHUTTER] = last_port_buttons[3] & ~smp.port1_levels[5];
    ev[EV_RECORD]  = ~last_record_pressed & rec;
    ev[EV_MENU]    = last_port_buttons[4] & ~smp.port1_levels[4];
    last_record_pressed_next = rec;
    last_port_buttons_next = {smp.port1_levels[4], smp.port1_levels[5],
                              smp.port0_levels[4], smp.port0_levels[6], smp.port0_levels[5]};

    // Del + Menu hold: saturating count, one exit per hold
    both_held = ~smp.port0_levels[4] & ~smp.port1_levels[4];
    if (both_held) begin
      hold_count_next = (hold_count == HOLD_COUNT_MAX) ? hold_count : hold_count + 10'd1;
      ev[EV_EXIT]     = (hold_count_next >= cfg.hold_exit_ticks) & ~exit_sent;
      exit_sent_next  = exit_sent | ev[EV_EXIT];
    end else begin
      hold_count_next = 10'd0;
      exit_sent_next  = 1'b0;
    end

    // disabled joystick lines keep their remembered level
    for (int i = 0; i < NumJoy; i++) begin
      ev[EV_JOY_BASE+i] = cfg.joystick_enable_mask[i] & ~last_joystick_pressed[i]
                          & ~smp.joystick_levels[i];
      last_joystick_pressed_next[i] = cfg.joystick_enable_mask[i] ? ~smp.joystick_levels[i]
                                                                  : last_joystick_pressed[i];
    end

    btn_cnt = {3'b0, ev[EV_ALBUM]} + {3'b0, ev[EV_FN_PRESS]} + {3'b0, ev[EV_FN_RELEASE]}
            + {3'b0, ev[EV_DEL]} + {3'b0, ev[EV_SHUTTER]} + {3'b0, ev[EV_MENU]}
            + {3'b0, ev[EV_JOY_BASE]} + {3'b0, ev[EV_JOY_BASE+1]}
            + {3'b0, ev[EV_JOY_BASE+2]} + {3'b0, ev[EV_JOY_BASE+3]}
            + {3'b0, ev[EV_JOY_BASE+4]};
    lock = (mchg ? {4'b0, cfg.mode_lockout_ticks} : 12'd0)
         + ({8'b0, btn_cnt} * {4'b0, cfg.button_lockout_ticks})
         + (ev[EV_RECORD] ? {4'b0, cfg.record_lockout_ticks} : 12'd0);

    lockout_count_next = skip ? lockout_count - 12'd1 : lock;

    if (skip) begin
      res = '0;
      res.dial_value   = acc_valid ? dial_accepted : 4'd0;
      res.video_mode   = last_video;
      res.tick_skipped = 1'b1;
    end else begin
      res.button_events         = ev;
      res.dial_changed          = dchg;
      res.dial_value            = acc_valid_next ? dial_accepted_next : 4'd0;
      res.mode_changed          = mchg;
      res.video_mode            = last_video_next;
      res.scroll_valid          = sv;
      res.scroll_forward        = sv & (enc_a ^ enc_b);
      res.scroll_switch_pressed = sv & ~enc_sw;
      res.tick_skipped          = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lockout_count         <= 12'd0;
      cand_valid            <= 1'b0;
      dial_stable_count     <= 4'd0;
      acc_valid             <= 1'b0;
      last_video            <= 1'b0;
      last_port_buttons     <= 5'h1F;
      last_record_pressed   <= 1'b0;
      last_joystick_pressed <= 5'd0;
      last_encoder_a        <= 1'b0;
      hold_count            <= 10'd0;
      exit_sent             <= 1'b0;
    end else if (take) begin
      lockout_count <= lockout_count_next;
      if (!skip) begin
        cand_valid            <= cand_valid_next;
        dial_stable_count     <= dial_stable_count_next;
        acc_valid             <= acc_valid_next;
        last_video            <= last_video_next;
        last_port_buttons     <= last_port_buttons_next;
        last_record_pressed   <= last_record_pressed_next;
        last_joystick_pressed <= last_joystick_pressed_next;
        last_encoder_a        <= last_encoder_a_next;
        hold_count            <= hold_count_next;
        exit_sent             <= exit_sent_next;
      end
    end
  end

  // dial values are qualified by their valid bits
  always_ff @(posedge clk) begin
    if (take && !skip) begin
      dial_candidate <= dial_candidate_next;
      dial_accepted  <= dial_accepted_next;
    end
  end

endmodule

FILE: hdl/ccq_out_buf.sv
// Two-entry result buffer: output register plus skid entry.
// Depends on ccq_pkg. Ready toward the core comes from a register only.
module ccq_out_buf (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  ccq_pkg::result_t push_data,
  output logic             can_push,
  output logic             head_valid,
  input  logic             pop,
  output ccq_pkg::result_t head_data
);
  import ccq_pkg::*;

  logic [1:0] count;
  result_t    q0, q1;

  assign head_valid = (count != 2'd0);
  assign can_push   = (count != 2'd2);
  assign head_data  = q0;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (push && !pop) begin
      count <= count + 2'd1;
    end else if (pop && !push) begin
      count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push && pop) begin
      if (count == 2'd1) begin
        q0 <= push_data;
      end else begin
        q0 <= q1;
        q1 <= push_data;
      end
    end else if (push) begin
      if (count == 2'd0) begin
        q0 <= push_data;
      end else begin
        q1 <= push_data;
      end
    end else if (pop) begin
      q0 <= q1;
    end
  end

endmodule

FILE: hdl/camera_control_input_qualifier.sv
// Top level of the camera control input qualifier: config registers, core, result buffer.
// Depends on ccq_pkg, ccq_if, ccq_core and ccq_out_buf.
//
//   channel   dir  handshake     contents
//   sample    in   valid/ready   port0, port1, record line, joystick levels
//   result    out  valid/ready   events, dial, mode, scroll, skip flag
//   cfg_*     in   write enable  register index and data, no read-back
//
// One sample per cycle while the buffer has room; each result is registered in the buffer.
// The whole tick is evaluated in one pass of logic into a two-entry result buffer,
// so a stalled result costs nothing until both entries are full.
// Synchronous reset restores the register defaults and clears all history or its valid bits.
module camera_control_input_qualifier (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [ccq_pkg::CfgIndexWidth-1:0]    cfg_index,
  input  logic [ccq_pkg::CfgDataWidth-1:0]     cfg_data,
  ccq_sample_if.sink                           sample,
  ccq_result_if.source                         result
);
  import ccq_pkg::*;

  cfg_t    cfg;
  sample_t smp;
  result_t core_res, head;
  logic    take, can_push, head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.button_lockout_ticks <= BUTTON_LOCKOUT_RST;
      cfg.mode_lockout_ticks   <= MODE_LOCKOUT_RST;
      cfg.record_lockout_ticks <= RECORD_LOCKOUT_RST;
      cfg.dial_stable_ticks    <= DIAL_STABLE_RST;
      cfg.hold_exit_ticks      <= HOLD_EXIT_RST;
      cfg.record_line_enable   <= RECORD_LINE_EN_RST;
      cfg.joystick_enable_mask <= JOYSTICK_MASK_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_BUTTON_LOCKOUT: cfg.button_lockout_ticks <= cfg_data[7:0];
        REG_MODE_LOCKOUT:   cfg.mode_lockout_ticks   <= cfg_data[7:0];
        REG_RECORD_LOCKOUT: cfg.record_lockout_ticks <= cfg_data[7:0];
        REG_DIAL_STABLE:    cfg.dial_stable_ticks    <= cfg_data[3:0];
        REG_HOLD_EXIT:      cfg.hold_exit_ticks      <= cfg_data[9:0];
        REG_RECORD_LINE_EN: cfg.record_line_enable   <= cfg_data[0];
        REG_JOYSTICK_MASK:  cfg.joystick_enable_mask <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  assign smp.port0_levels      = sample.port0_levels;
  assign smp.port1_levels      = sample.port1_levels;
  assign smp.record_line_level = sample.record_line_level;
  assign smp.joystick_levels   = sample.joystick_levels;

  assign sample.ready = can_push;
  assign take         = sample.valid & can_push;

  ccq_core u_core (
    .clk (clk),
    .rst (rst),
    .cfg (cfg),
    .take(take),
    .smp (smp),
    .res (core_res)
  );

  ccq_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (take),
    .push_data (core_res),
    .can_push  (can_push),
    .head_valid(head_valid),
    .pop       (head_valid & result.ready),
    .head_data (head)
  );

  assign result.valid                 = head_valid;
  assign result.button_events         = head.button_events;
  assign result.dial_changed          = head.dial_changed;
  assign result.dial_value            = head.dial_value;
  assign result.mode_changed          = head.mode_changed;
  assign result.video_mode            = head.video_mode;
  assign result.scroll_valid          = head.scroll_valid;
  assign result.scroll_forward        = head.scroll_forward;
  assign result.scroll_switch_pressed = head.scroll_switch_pressed;
  assign result.tick_skipped          = head.tick_skipped;

endmodule
